/* design/lpfp_pkg.sv */
package lpfp_pkg;

    // Largest payload length that a frame may announce.
    localparam int unsigned MAX_PAYLOAD = 256;

    localparam int unsigned COUNT_W = 17;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CFG_IDX_W = 1;

    // Header bytes ahead of the payload: address and two length bytes.
    localparam logic [COUNT_W-1:0] HEADER_BYTES = COUNT_W'(3);
    localparam logic [COUNT_W-1:0] MAX_COUNT    = COUNT_W'(MAX_PAYLOAD);
    localparam logic [LEN_W-1:0]   MAX_LEN      = LEN_W'(MAX_PAYLOAD);
    localparam logic [BYTE_W-1:0]  DROP_IDS     = BYTE_W'(4);
    localparam logic [BYTE_W-1:0]  FIRE_IDS     = BYTE_W'(2);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_START   = 1'b1;

    // Reported status codes.
    localparam logic [1:0] ST_AWAIT      = 2'd0;
    localparam logic [1:0] ST_INCOMPLETE = 2'd1;
    localparam logic [1:0] ST_READY      = 2'd2;
    localparam logic [1:0] ST_ERROR      = 2'd3;

    localparam logic [BYTE_W-1:0] PACKET_START_RST = 8'd1;
    localparam logic [BYTE_W-1:0] DROP_START_RST   = 8'd2;

    typedef enum logic [4:0] {
        MODE_AWAIT      = 5'b00001,
        MODE_INCOMPLETE = 5'b00010,
        MODE_READY      = 5'b00100,
        MODE_ERROR      = 5'b01000,
        MODE_DROP_ID    = 5'b10000
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [COUNT_W-1:0] byte_count;
        logic [LEN_W-1:0]   wanted_length;
        logic [BYTE_W-1:0]  address;
        logic [BYTE_W-1:0]  len_high;
    } parse_state_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              drop_fire;
        logic              drop_device;
        logic              payload_valid;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] frame_address;
        logic [LEN_W-1:0]  frame_length;
    } result_t;

endpackage

/* design/length_prefixed_frame_parser_unit.sv */
// A transaction accepted into the input register is parsed into the result register as soon
// as that register can take it and is offered on the m_ port from then on; a stalled
// consumer holds it back in the input register.
// Throughput: one byte per cycle; the input register and the result register each take a
// new transaction whenever the stage after them moves on.
// Reset (aresetn low, synchronous): parser goes to awaiting with zeroed count, length and
// address, both pipeline registers empty, start codes back to 1 and 2.
module length_prefixed_frame_parser_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration writes.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lpfp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lpfp_pkg::BYTE_W-1:0]        cfg_data,
    // Incoming byte stream.
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_command,
    input  logic [lpfp_pkg::BYTE_W-1:0]        s_data_byte,
    // Parse results.
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_status,
    output logic                               m_drop_fire,
    output logic                               m_drop_device,
    output logic                               m_payload_valid,
    output logic [lpfp_pkg::BYTE_W-1:0]        m_payload_byte,
    output logic [lpfp_pkg::BYTE_W-1:0]        m_frame_address,
    output logic [lpfp_pkg::LEN_W-1:0]         m_frame_length
);

    // Start code registers, always ready; user writes must come only while idle (not enforced).
    logic [lpfp_pkg::BYTE_W-1:0] packet_start_reg;
    logic [lpfp_pkg::BYTE_W-1:0] drop_start_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            packet_start_reg <= lpfp_pkg::PACKET_START_RST;
            drop_start_reg   <= lpfp_pkg::DROP_START_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                lpfp_pkg::CFG_PACKET_START: packet_start_reg <= cfg_data;
                lpfp_pkg::CFG_DROP_START:   drop_start_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register. It holds one transaction until the parse step can hand its result to
    // the result register; it refills in the same cycle that it drains.
    logic                        in_valid_reg;
    logic                        in_command_reg;
    logic [lpfp_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        step_fire;

    assign step_fire = in_valid_reg && (!m_valid || m_ready);
    assign s_ready   = !in_valid_reg || step_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_command_reg <= s_command;
            in_byte_reg    <= s_data_byte;
        end
    end

    // Parser state. It advances exactly once per byte, at the edge where that byte's result
    // enters the result register, so the next byte always sees its predecessor's effect.
    lpfp_pkg::parse_state_t state_reg;
    lpfp_pkg::parse_state_t state_next;
    lpfp_pkg::result_t      res_next;
    lpfp_pkg::result_t      res_reg;
    logic                   out_valid_reg;

    lpfp_step u_step (
        .cur          (state_reg),
        .packet_start (packet_start_reg),
        .drop_start   (drop_start_reg),
        .command      (in_command_reg),
        .data_byte    (in_byte_reg),
        .nxt          (state_next),
        .res          (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode          <= lpfp_pkg::MODE_AWAIT;
            state_reg.byte_count    <= '0;
            state_reg.wanted_length <= '0;
            state_reg.address       <= '0;
            state_reg.len_high      <= '0;
        end else if (step_fire) begin
            state_reg <= state_next;
        end
    end

    // Result register. It keeps its transaction while the consumer stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_fire) begin
            res_reg <= res_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = res_reg.status;
    assign m_drop_fire     = res_reg.drop_fire;
    assign m_drop_device   = res_reg.drop_device;
    assign m_payload_valid = res_reg.payload_valid;
    assign m_payload_byte  = res_reg.payload_byte;
    assign m_frame_address = res_reg.frame_address;
    assign m_frame_length  = res_reg.frame_length;

    // A parsed byte always lands in the result register.
    a_step_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire |=> m_valid)
        else $error("parsed transaction did not reach the result register");

    // The count never runs more than one past the largest payload.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.byte_count <= lpfp_pkg::MAX_COUNT + lpfp_pkg::COUNT_W'(1))
        else $error("byte count ran past its bound");

    // A drop release is reported only as an incomplete status.
    a_drop_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_drop_fire) |-> (m_status == lpfp_pkg::ST_INCOMPLETE))
        else $error("drop release with unexpected status");

    // A payload byte never comes with an awaiting or error status.
    a_payload_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload_valid) |->
            (m_status == lpfp_pkg::ST_INCOMPLETE || m_status == lpfp_pkg::ST_READY))
        else $error("payload byte with unexpected status");

    // The device select only carries meaning alongside a release.
    a_device_with_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_drop_device) |-> m_drop_fire)
        else $error("drop device set without a release");

endmodule

/* design/lpfp_step.sv */
module lpfp_step (
    input  lpfp_pkg::parse_state_t    cur,
    input  logic [lpfp_pkg::BYTE_W-1:0] packet_start,
    input  logic [lpfp_pkg::BYTE_W-1:0] drop_start,
    input  logic                      command,
    input  logic [lpfp_pkg::BYTE_W-1:0] data_byte,
    output lpfp_pkg::parse_state_t    nxt,
    output lpfp_pkg::result_t         res
);

    logic [lpfp_pkg::COUNT_W-1:0] count_inc;
    logic [lpfp_pkg::COUNT_W-1:0] frame_end;
    logic [lpfp_pkg::LEN_W-1:0]   new_length;

    assign count_inc  = cur.byte_count + lpfp_pkg::COUNT_W'(1);
    assign frame_end  = {1'b0, cur.wanted_length} + lpfp_pkg::HEADER_BYTES;
    assign new_length = {cur.len_high, data_byte};

    always_comb begin
        nxt = cur;
        res = '0;
        res.status = lpfp_pkg::ST_AWAIT;
        priority if (command) begin
            nxt.byte_count    = '0;
            nxt.wanted_length = '0;
            nxt.mode          = lpfp_pkg::MODE_AWAIT;
        end else if (cur.byte_count > lpfp_pkg::MAX_COUNT || cur.mode == lpfp_pkg::MODE_READY
                     || cur.mode == lpfp_pkg::MODE_ERROR) begin
            nxt.byte_count = '0;
            nxt.mode       = lpfp_pkg::MODE_AWAIT;
            res.status     = lpfp_pkg::ST_ERROR;
        end else if (cur.mode == lpfp_pkg::MODE_AWAIT && cur.byte_count == '0) begin
            // The packet start code takes precedence when both codes match.
            priority if (data_byte == packet_start) begin
                nxt.mode   = lpfp_pkg::MODE_INCOMPLETE;
                res.status = lpfp_pkg::ST_INCOMPLETE;
            end else if (data_byte == drop_start) begin
                nxt.mode       = lpfp_pkg::MODE_DROP_ID;
                nxt.byte_count = lpfp_pkg::COUNT_W'(1);
                res.status     = lpfp_pkg::ST_INCOMPLETE;
            end else begin
                res.status = lpfp_pkg::ST_AWAIT;
            end
        end else if (cur.mode == lpfp_pkg::MODE_DROP_ID) begin
            if (data_byte < lpfp_pkg::DROP_IDS) begin
                res.drop_fire   = (data_byte < lpfp_pkg::FIRE_IDS);
                res.drop_device = (data_byte < lpfp_pkg::FIRE_IDS) & data_byte[0];
                nxt.mode        = lpfp_pkg::MODE_READY;
                res.status      = lpfp_pkg::ST_INCOMPLETE;
            end else begin
                nxt.mode   = lpfp_pkg::MODE_ERROR;
                res.status = lpfp_pkg::ST_ERROR;
            end
        end else begin
            // Frame body: address, length high, length low, then payload.
            if (cur.byte_count == '0) begin
                nxt.address = data_byte;
            end
            if (cur.byte_count == lpfp_pkg::COUNT_W'(1)) begin
                nxt.len_high = data_byte;
            end
            nxt.byte_count = count_inc;
            if (count_inc == lpfp_pkg::HEADER_BYTES) begin
                nxt.wanted_length = new_length;
                res.status = (new_length > lpfp_pkg::MAX_LEN) ? lpfp_pkg::ST_ERROR
                                                              : lpfp_pkg::ST_INCOMPLETE;
            end else begin
                if (count_inc > lpfp_pkg::HEADER_BYTES && count_inc <= frame_end
                    && cur.wanted_length <= lpfp_pkg::MAX_LEN) begin
                    res.payload_valid = 1'b1;
                    res.payload_byte  = data_byte;
                end
                res.status = (count_inc == frame_end && count_inc > lpfp_pkg::HEADER_BYTES)
                           ? lpfp_pkg::ST_READY : lpfp_pkg::ST_INCOMPLETE;
            end
        end
        res.frame_address = nxt.address;
        res.frame_length  = nxt.wanted_length;
    end

endmodule
